@@ rtl/core/sfpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed fixed-point ALU package
// Operation and status codes shared by the ALU modules.
// ----------------------------------------------------------------------------
package sfpa_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_NEGRT = 2'd3;

  localparam logic [1:0] M_MUL = 2'd0;
  localparam logic [1:0] M_DIV = 2'd1;
  localparam logic [1:0] M_SQRT = 2'd2;

  localparam logic [31:0] HALF_WORD = 32'h8000_0000;

endpackage

@@ rtl/core/sfpa_req_if.sv @@
// ----------------------------------------------------------------------------
// ALU request channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface sfpa_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

@@ rtl/core/sfpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ALU response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface sfpa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [1:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

@@ rtl/core/sfpa_iter.sv @@
// ----------------------------------------------------------------------------
// Shared iterative unit
// Restoring divide, shift-add multiply and bit-wise square root, one bit a
// cycle, each mode with its own add/compare logic over shared registers.
// ----------------------------------------------------------------------------
module sfpa_iter
  import sfpa_pkg::*;
#(
  parameter int TB = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    mode,
  input  logic [TB-1:0] x,
  input  logic [TB-1:0] y,
  output logic          done,
  output logic [TB-1:0] q,
  output logic [TB-1:0] hi,
  output logic          big
);
  localparam int FB = TB - 32;
  localparam int NB = TB + FB;
  localparam int CW = $clog2(NB + 1);

  logic          busy_r, busy_nxt;
  logic          done_r;
  logic          fin;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    mode_r;
  logic [NB-1:0] n_r, n_nxt;
  logic [TB:0]   rem_r, rem_nxt;
  logic [TB-1:0] acc_r, acc_nxt;
  logic [TB-1:0] y_r;
  logic [2*TB-1:0] sq_r, sq_nxt, p_r, p_nxt, d_r, d_nxt;
  logic          big_r, big_nxt;
  logic [TB:0]   sh;
  logic [TB:0]   diff;
  logic [2*TB+1:0] trial;
  logic [2*TB-1:0] cand;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    n_nxt = n_r;
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    sq_nxt = sq_r;
    p_nxt = p_r;
    d_nxt = d_r;
    big_nxt = big_r;
    sh = '0;
    diff = '0;
    trial = '0;
    cand = '0;
    fin = 1'b0;
    if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (mode_r == M_DIV) begin
        sh = {rem_r[TB-1:0], n_r[NB-1]};
        diff = sh - {1'b0, y_r};
        n_nxt = {n_r[NB-2:0], 1'b0};
        if (!diff[TB]) begin
          rem_nxt = diff;
          if (cnt_r > CW'(TB)) big_nxt = 1'b1;
          else acc_nxt = {acc_r[TB-2:0], 1'b1};
        end else begin
          rem_nxt = sh;
          if (cnt_r <= CW'(TB)) acc_nxt = {acc_r[TB-2:0], 1'b0};
        end
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          fin = 1'b1;
        end
      end else if (mode_r == M_MUL) begin
        p_nxt = {1'b0, p_r[2*TB-1:1]};
        if (acc_r[0]) begin
          trial = {2'b0, p_r} + {1'b0, y_r, {TB{1'b0}}};
          p_nxt = trial[2*TB:1];
        end
        acc_nxt = {1'b0, acc_r[TB-1:1]};
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          fin = 1'b1;
        end
      end else begin
        // The remainder n - r^2 sits in sq_r, r*2^(i+1) in p_r and 2^(2i) in d_r.
        cand = p_r | d_r;
        trial = {2'b0, sq_r} - {2'b0, cand};
        if (!trial[2*TB+1]) begin
          sq_nxt = trial[2*TB-1:0];
          p_nxt = {1'b0, p_r[2*TB-1:1]} | d_r;
          acc_nxt = {acc_r[TB-2:0], 1'b1};
        end else begin
          p_nxt = {1'b0, p_r[2*TB-1:1]};
          acc_nxt = {acc_r[TB-2:0], 1'b0};
        end
        d_nxt = {2'b0, d_r[2*TB-1:2]};
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          fin = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      y_r <= y;
      rem_r <= '0;
      big_r <= 1'b0;
      sq_r <= {{(2*TB-NB){1'b0}}, x, {FB{1'b0}}};
      p_r <= '0;
      d_r <= {2'b01, {(2*TB-2){1'b0}}};
      n_r <= {x, {FB{1'b0}}};
      if (mode == M_MUL) begin
        acc_r <= x;
        cnt_r <= CW'(TB);
      end else if (mode == M_DIV) begin
        acc_r <= '0;
        cnt_r <= CW'(NB);
      end else begin
        acc_r <= '0;
        cnt_r <= CW'(TB);
      end
    end else begin
      cnt_r <= cnt_nxt;
      n_r <= n_nxt;
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      sq_r <= sq_nxt;
      p_r <= p_nxt;
      d_r <= d_nxt;
      big_r <= big_nxt;
    end
  end

  assign done = done_r;
  assign q = (mode_r == M_MUL) ? p_r[TB-1:0] : acc_r;
  assign hi = p_r[2*TB-1:TB];
  assign big = big_r;
endmodule

@@ rtl/core/signed_fixed_point_alu_core.sv @@
// ----------------------------------------------------------------------------
// Signed fixed-point ALU core
// Q32.32 add, subtract, negate, multiply, divide and square root.
//
//   channel | dir | words
//   in_     | in  | operation, operand_a, operand_b
//   out_    | out | result_value, status
//
// Add, subtract, negate, zero divisors and negative roots go straight to the
// result register; other multiply, divide and square root words run in the
// shared unit, one bit a cycle. Reset clears the sequencer and output valid.
// A stalled result holds the core; no new word is taken until it has left.
// ----------------------------------------------------------------------------
module signed_fixed_point_alu_core
  import sfpa_pkg::*;
#(
  parameter int WORDS = 2
) (
  input logic clk,
  input logic rst_n,
  sfpa_req_if.sink in_ch,
  sfpa_rsp_if.source out_ch
);
  localparam int TB = 32 * WORDS;
  localparam int FB = TB - 32;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0]    st_r;
  logic [2:0]    op_r;
  logic [TB-1:0] ma, mb;
  logic          neg_r;
  logic [63:0]   val_r;
  logic [1:0]    stat_r;
  logic [63:0]   val0;
  logic [1:0]    stat0;
  logic          start, done, big;
  logic [TB-1:0] uq, uhi;
  logic [1:0]    umode;
  logic [TB-1:0] av, bv, lim, val, mlo;
  logic [1:0]    stat;
  logic          mcarry, rnd;
  logic [TB:0]   msum;
  logic [TB-1:0] mhi;

  assign av = in_ch.operand_a[TB-1:0];
  assign bv = in_ch.operand_b[TB-1:0];
  assign ma = av[TB-1] ? (~av + 1'b1) : av;
  assign mb = bv[TB-1] ? (~bv + 1'b1) : bv;
  assign in_ch.ready = (st_r == S_IDLE);
  assign start = in_ch.valid && in_ch.ready &&
                 (in_ch.operation == OP_MUL || in_ch.operation == OP_DIV ||
                  (in_ch.operation == OP_SQRT && !av[TB-1]));
  assign umode = (in_ch.operation == OP_MUL) ? M_MUL :
                 (in_ch.operation == OP_DIV) ? M_DIV : M_SQRT;

  sfpa_iter #(.TB(TB)) u_iter (
    .clk(clk), .rst_n(rst_n), .start(start && !(in_ch.operation == OP_DIV && mb == '0)),
    .mode(umode), .x(in_ch.operation == OP_SQRT ? av : ma), .y(mb),
    .done(done), .q(uq), .hi(uhi), .big(big)
  );

  // Product p = {uhi,uq}; keep p >> FB, round on the 32 bits below.
  always_comb begin
    mhi = '0;
    mlo = '0;
    rnd = 1'b0;
    if (FB == 0) begin
      mlo = uq;
      mhi = uhi;
    end else begin
      mlo = TB'({uhi, uq} >> FB);
      mhi = TB'({uhi, uq} >> (FB + TB));
      rnd = 32'(uq >> (FB - 32 < 0 ? 0 : FB - 32)) > HALF_WORD;
    end
    msum = {1'b0, mlo} + {{TB{1'b0}}, rnd};
    mcarry = msum[TB];
  end

  assign lim = neg_r ? {1'b1, {(TB-1){1'b0}}} : {1'b0, {(TB-1){1'b1}}};

  always_comb begin
    val = '0;
    stat = ST_OK;
    if (op_r == OP_MUL) begin
      if (mhi != '0 || mcarry || msum[TB-1:0] > lim) stat = ST_OVF;
      val = neg_r ? (~msum[TB-1:0] + 1'b1) : msum[TB-1:0];
    end else if (op_r == OP_DIV) begin
      if (big || uq > lim) begin
        stat = ST_OVF;
        val = lim;
      end else begin
        val = neg_r ? (~uq + 1'b1) : uq;
      end
    end else begin
      val = uq;
    end
  end

  always_comb begin
    val0 = '0;
    stat0 = ST_OK;
    case (in_ch.operation)
      OP_ADD: val0 = 64'(signed'(av + bv));
      OP_SUB: val0 = 64'(signed'(av - bv));
      OP_NEG: begin
        val0 = 64'(signed'(~av + 1'b1));
        if (av == {1'b1, {(TB-1){1'b0}}}) stat0 = ST_OVF;
      end
      OP_DIV: begin
        if (mb == '0) begin
          stat0 = ST_DIVZ;
          val0 = av[TB-1] ? 64'(signed'({1'b1, {(TB-1){1'b0}}}))
                          : 64'(signed'({1'b0, {(TB-1){1'b1}}}));
        end
      end
      OP_SQRT: if (av[TB-1]) stat0 = ST_NEGRT;
      default: val0 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid) st_r <= start && !(in_ch.operation == OP_DIV && mb == '0)
                                   ? S_RUN : S_OUT;
        end
        S_RUN: begin
          if (done) st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_ch.valid) begin
      op_r <= in_ch.operation;
      neg_r <= av[TB-1] ^ bv[TB-1];
      stat_r <= stat0;
      val_r <= val0;
    end else if (st_r == S_RUN && done) begin
      val_r <= 64'(signed'(val));
      stat_r <= stat;
    end
  end

  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.result_value = val_r;
  assign out_ch.status = stat_r;
endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Signed fixed-point ALU core testbench
// Drives operation words through the request channel and checks each result
// word against a Q32.32 prediction of add, subtract, negate, multiply,
// divide and square root, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import sfpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function alu_result_t compute(logic [2:0] op, logic [63:0] a, logic [63:0] b);
      alu_result_t r;
      logic sa, sb, neg;
      logic [63:0] ma, mb, lim;
      logic [127:0] p, m, q, cc, n;
      logic [63:0] root, c;
      sa = a[63];
      sb = b[63];
      neg = sa ^ sb;
      ma = sa ? -a : a;
      mb = sb ? -b : b;
      lim = neg ? MOST_NEG : MOST_POS;
      r.value = '0;
      r.status = ST_OK;
      case (op)
        OP_ADD: r.value = a + b;
        OP_SUB: r.value = a - b;
        OP_NEG: begin
          r.value = -a;
          if (a == MOST_NEG) r.status = ST_OVF;
        end
        OP_MUL: begin
          p = {64'd0, ma} * {64'd0, mb};
          m = p >> 32;
          if (p[31:0] > HALF_WORD) m = m + 1;
          if (m[127:64] != 0 || m[63:0] > lim) r.status = ST_OVF;
          r.value = neg ? -m[63:0] : m[63:0];
        end
        OP_DIV: begin
          if (mb == 0) begin
            r.status = ST_DIVZ;
            r.value = sa ? MOST_NEG : MOST_POS;
          end else begin
            q = ({64'd0, ma} << 32) / {64'd0, mb};
            if (q[127:64] != 0 || q[63:0] > lim) begin
              r.status = ST_OVF;
              r.value = neg ? MOST_NEG : MOST_POS;
            end else begin
              r.value = neg ? -q[63:0] : q[63:0];
            end
          end
        end
        OP_SQRT: begin
          if (sa) begin
            r.status = ST_NEGRT;
          end else begin
            n = {64'd0, a} << 32;
            root = '0;
            for (int i = 63; i >= 0; i--) begin
              c = root | (64'd1 << i);
              cc = {64'd0, c} * {64'd0, c};
              if (cc <= n) root = c;
            end
            r.value = root;
          end
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_request(logic [2:0] op, logic [63:0] a, logic [63:0] b);
      pending.push_back(compute(op, a, b));
    endfunction

    function void check_result(logic [63:0] value, logic [1:0] status);
      alu_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time, value, status);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.value !== value) begin
        $display("%0t: value mismatch expected=%h actual=%h", $time, e.value, value);
        errors++;
      end
      if (e.status !== status) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  alu_scoreboard sb = new();

  sfpa_req_if in_ch();
  sfpa_rsp_if out_ch();

  signed_fixed_point_alu_core #(.WORDS(2)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.operation, in_ch.operand_a, in_ch.operand_b);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_value, out_ch.status);
  end

  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          hold++;
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  task automatic send_word(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    in_ch.operation <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (!calm && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(16)) - 8) <<< 32;
      2: return {{32{1'b0}}, $urandom};
      3: return 64'($signed({$urandom_range(255), $urandom}) - 64'sh80_0000_0000);
      4: begin
        case ($urandom_range(3))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return 64'd0;
          default: return -ONE;
        endcase
      end
      default: return {{16{1'b0}}, 16'($urandom_range(65535)), $urandom};
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_ADD, MOST_POS, 64'd1);
    send_word(OP_ADD, MOST_NEG, MOST_NEG);
    send_word(OP_SUB, MOST_NEG, 64'd1);
    send_word(OP_SUB, 64'd0, MOST_NEG);
    send_word(OP_NEG, MOST_NEG, 64'd0);
    send_word(OP_NEG, 64'd0, MOST_POS);
    send_word(OP_NEG, MOST_POS, 64'd5);
    send_word(OP_MUL, MOST_NEG, ONE);
    send_word(OP_MUL, MOST_POS, MOST_POS);
    send_word(OP_MUL, MOST_NEG, -ONE);
    send_word(OP_MUL, 64'd1, 64'h8000_0000);
    send_word(OP_MUL, 64'd1, 64'h8000_0001);
    send_word(OP_MUL, -64'd1, 64'h8000_0001);
    send_word(OP_DIV, -ONE, 64'd0);
    send_word(OP_DIV, 64'd0, 64'd0);
    send_word(OP_DIV, ONE, 64'd0);
    send_word(OP_DIV, MOST_NEG, -ONE);
    send_word(OP_DIV, MOST_NEG, ONE);
    send_word(OP_DIV, MOST_POS, 64'd1);
    send_word(OP_DIV, 64'd7 << 32, -(64'd2 << 32));
    send_word(OP_SQRT, -64'd1, 64'd0);
    send_word(OP_SQRT, MOST_POS, MOST_NEG);
    send_word(OP_SQRT, 64'd0, 64'd0);
    send_word(3'd6, MOST_NEG, MOST_POS);
    send_word(3'd7, {$urandom, $urandom}, {$urandom, $urandom});

    for (int i = 0; i < 1050; i++) begin
      if (i == 200) calm = 1'b1;
      if (i == 400) calm = 1'b0;
      if (i == 600) hold_request = 1'b1;
      op = ($urandom_range(49) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
      send_word(op, pick_operand(), pick_operand());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d results from 1075 words covering all six operations,",
             sb.checked);
    $display("operand extremes, rounding, overflow, zero divisors and negative roots.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/sfpa_pkg.sv
rtl/core/sfpa_req_if.sv
rtl/core/sfpa_rsp_if.sv
rtl/core/sfpa_iter.sv
rtl/core/signed_fixed_point_alu_core.sv
tb/tb.sv
